[hw/rtl/dwsc_pkg.sv]
// Shared types, register indexes and screen stepping helpers for the
// display wake and swipe controller. No dependencies.
package dwsc_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_COUNT   = 3'd0,
        CFG_STANDBY_SCREEN = 3'd1,
        CFG_STANDBY_TMO    = 3'd2,
        CFG_MOTION_COOL    = 3'd3,
        CFG_GESTURE_MAX    = 3'd4,
        CFG_SWIPE_MIN_DX   = 3'd5,
        CFG_TAP_MAX_DX     = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        GEST_NONE  = 2'd0,
        GEST_TAP   = 2'd1,
        GEST_LEFT  = 2'd2,
        GEST_RIGHT = 2'd3
    } t_gesture;

    typedef struct packed {
        logic [3:0]  screen_count;
        logic [3:0]  standby_screen;
        logic [31:0] standby_timeout_ms;
        logic [15:0] motion_cooldown_ms;
        logic [15:0] gesture_max_ms;
        logic [11:0] swipe_min_dx;
        logic [11:0] tap_max_dx;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        screen_count:       4'd3,
        standby_screen:     4'd3,
        standby_timeout_ms: 32'd60000,
        motion_cooldown_ms: 16'd2000,
        gesture_max_ms:     16'd1500,
        swipe_min_dx:       12'd40,
        tap_max_dx:         12'd20
    };

    typedef struct packed {
        logic [31:0] now_ms;
        logic        button_down;
        logic        touch_present;
        logic [11:0] touch_x;
        logic        motion;
        logic        force_redraw;
        logic        redraw_ack;
    } t_poll;

    typedef struct packed {
        logic [3:0]  screen_now;
        logic [3:0]  saved_screen;
        logic        standby_flag;
        logic [31:0] last_activity_ms;
        logic        motion_high;
        logic [31:0] last_motion_wake_ms;
        logic        button_held;
        logic        touching;
        logic [11:0] touch_first_x;
        logic [11:0] touch_latest_x;
        logic [31:0] touch_begin_ms;
        logic        redraw_pending;
    } t_state;

    localparam t_state STATE_RESET = '{
        screen_now:          4'd0,
        saved_screen:        4'd0,
        standby_flag:        1'b0,
        last_activity_ms:    32'd0,
        motion_high:         1'b0,
        last_motion_wake_ms: 32'd0,
        button_held:         1'b0,
        touching:            1'b0,
        touch_first_x:       12'd0,
        touch_latest_x:      12'd0,
        touch_begin_ms:      32'd0,
        redraw_pending:      1'b1
    };

    typedef struct packed {
        logic [3:0] screen;
        logic       in_standby;
        logic       redraw_needed;
        logic       motion_wake;
        t_gesture   gesture;
    } t_result;

    // a count of zero behaves as a single screen
    function automatic logic [3:0] eff_count(input logic [3:0] count);
        return (count == 4'd0) ? 4'd1 : count;
    endfunction

    function automatic logic [3:0] next_screen(input logic [3:0] s,
                                               input logic [3:0] count);
        logic [4:0] sum;
        sum = {1'b0, s} + 5'd1;
        return (sum >= {1'b0, eff_count(count)}) ? 4'd0 : sum[3:0];
    endfunction

    function automatic logic [3:0] prev_screen(input logic [3:0] s,
                                               input logic [3:0] count);
        return (s == 4'd0) ? (eff_count(count) - 4'd1) : (s - 4'd1);
    endfunction

endpackage

[hw/rtl/dwsc_cfg.sv]
// Configuration register bank of the display controller.
// Depends on dwsc_pkg for the register indexes and reset values.
module dwsc_cfg
    import dwsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_SCREEN_COUNT:   n_cfg.screen_count       = i_cfg_wdata[3:0];
                CFG_STANDBY_SCREEN: n_cfg.standby_screen     = i_cfg_wdata[3:0];
                CFG_STANDBY_TMO:    n_cfg.standby_timeout_ms = i_cfg_wdata[31:0];
                CFG_MOTION_COOL:    n_cfg.motion_cooldown_ms = i_cfg_wdata[15:0];
                CFG_GESTURE_MAX:    n_cfg.gesture_max_ms     = i_cfg_wdata[15:0];
                CFG_SWIPE_MIN_DX:   n_cfg.swipe_min_dx       = i_cfg_wdata[11:0];
                CFG_TAP_MAX_DX:     n_cfg.tap_max_dx         = i_cfg_wdata[11:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/dwsc_step.sv]
// Next-state and result logic for one poll: button, touch, motion, timeout.
// Depends on dwsc_pkg for the state, poll, result types and screen helpers.
module dwsc_step
    import dwsc_pkg::*;
(
    input  t_cfg    i_cfg,
    input  t_state  i_state,
    input  t_poll   i_poll,
    output t_state  o_state,
    output t_result o_result
);

    logic               btn_press;
    logic               release_ev;
    logic               gest_in_time;
    logic signed [12:0] dx;
    logic signed [12:0] adx;
    logic signed [12:0] sw;
    logic               go_right;
    logic               go_left;
    logic               go_tap;
    logic               mot_rise;
    logic               mwake;
    logic               woke;
    logic               timeout;
    logic               redraw0;
    logic [31:0]        idle_ms;
    logic [31:0]        touch_ms;
    logic [31:0]        cool_ms;
    logic [3:0]         scr_base;
    logic [3:0]         scr_btn;
    logic [3:0]         scr_touch;
    t_gesture           gest;

    always_comb begin
        redraw0   = (i_state.redraw_pending & ~i_poll.redraw_ack) | i_poll.force_redraw;
        btn_press = i_poll.button_down & ~i_state.button_held;

        // touch release classification
        release_ev   = ~i_poll.touch_present & i_state.touching;
        touch_ms     = i_poll.now_ms - i_state.touch_begin_ms;
        gest_in_time = touch_ms < {16'd0, i_cfg.gesture_max_ms};
        dx  = $signed({1'b0, i_state.touch_latest_x}) - $signed({1'b0, i_state.touch_first_x});
        adx = dx[12] ? -dx : dx;
        sw  = $signed({1'b0, i_cfg.swipe_min_dx});
        go_right = release_ev & gest_in_time & (dx > sw);
        go_left  = release_ev & gest_in_time & ~(dx > sw) & (dx < -sw);
        go_tap   = release_ev & gest_in_time & ~(dx > sw) & ~(dx < -sw)
                 & (adx < $signed({1'b0, i_cfg.tap_max_dx}));
        if (go_right)     gest = GEST_RIGHT;
        else if (go_left) gest = GEST_LEFT;
        else if (go_tap)  gest = GEST_TAP;
        else              gest = GEST_NONE;

        // motion edge with cooldown
        mot_rise = i_poll.motion & ~i_state.motion_high;
        cool_ms  = i_poll.now_ms - i_state.last_motion_wake_ms;
        mwake    = mot_rise & (cool_ms >= {16'd0, i_cfg.motion_cooldown_ms});

        woke = btn_press | i_poll.touch_present | go_right | go_left | go_tap | mwake;

        // first wake of the poll restores the saved screen, moves apply after it
        scr_base  = (i_state.standby_flag & woke) ? i_state.saved_screen
                                                  : i_state.screen_now;
        scr_btn   = btn_press ? next_screen(scr_base, i_cfg.screen_count) : scr_base;
        if (go_right)
            scr_touch = prev_screen(scr_btn, i_cfg.screen_count);
        else if (go_left | go_tap)
            scr_touch = next_screen(scr_btn, i_cfg.screen_count);
        else
            scr_touch = scr_btn;

        // a wake in this poll resets the idle time to zero, so no timeout then
        idle_ms = i_poll.now_ms - i_state.last_activity_ms;
        timeout = ~i_state.standby_flag & ~woke & (idle_ms > i_cfg.standby_timeout_ms);

        o_state = i_state;
        o_state.button_held  = i_poll.button_down;
        o_state.motion_high  = i_poll.motion;
        o_state.touching     = i_poll.touch_present;
        if (i_poll.touch_present) begin
            o_state.touch_latest_x = i_poll.touch_x;
            if (!i_state.touching) begin
                o_state.touch_first_x  = i_poll.touch_x;
                o_state.touch_begin_ms = i_poll.now_ms;
            end
        end
        if (mwake) begin
            o_state.last_motion_wake_ms = i_poll.now_ms;
        end
        if (woke) begin
            o_state.last_activity_ms = i_poll.now_ms;
        end
        o_state.standby_flag   = (i_state.standby_flag & ~woke) | timeout;
        o_state.redraw_pending = redraw0 | (i_state.standby_flag & woke) | btn_press
                               | go_right | go_left | go_tap | timeout;
        if (timeout) begin
            o_state.saved_screen = scr_touch;
            o_state.screen_now   = i_cfg.standby_screen;
        end else begin
            o_state.screen_now   = scr_touch;
        end

        o_result.screen        = o_state.screen_now;
        o_result.in_standby    = o_state.standby_flag;
        o_result.redraw_needed = o_state.redraw_pending;
        o_result.motion_wake   = mwake;
        o_result.gesture       = gest;
    end

endmodule

[hw/rtl/display_wake_and_swipe_controller.sv]
// Display wake and swipe controller, top level.
// Throughput 1 request per cycle unless the result is stalled.
// Rate is set by the single state update per poll (step logic between input
// and result registers); a stalled result holds one request in the input register,
// after which o_ready drops until i_ready returns.
// Synchronous active-low reset: state and config to defaults, pipeline empty.
// Depends on dwsc_pkg, dwsc_cfg and dwsc_step.
module display_wake_and_swipe_controller
    import dwsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [31:0]           i_now_ms,
    input  logic                  i_button_down,
    input  logic                  i_touch_present,
    input  logic [11:0]           i_touch_x,
    input  logic                  i_motion,
    input  logic                  i_force_redraw,
    input  logic                  i_redraw_ack,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [3:0]            o_screen,
    output logic                  o_in_standby,
    output logic                  o_redraw_needed,
    output logic                  o_motion_wake,
    output logic [1:0]            o_gesture
);

    t_cfg    cfg;
    t_poll   r_poll;
    logic    r_in_valid;
    t_state  r_state;
    t_state  n_state;
    t_result r_res;
    t_result n_res;
    logic    r_out_valid;
    logic    advance;
    logic    in_take;

    dwsc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    dwsc_step u_step (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_poll   (r_poll),
        .o_state  (n_state),
        .o_result (n_res)
    );

    assign advance = r_in_valid & (~r_out_valid | i_ready);
    assign o_ready = ~r_in_valid | advance;
    assign in_take = i_valid & o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_poll.now_ms        <= i_now_ms;
            r_poll.button_down   <= i_button_down;
            r_poll.touch_present <= i_touch_present;
            r_poll.touch_x       <= i_touch_x;
            r_poll.motion        <= i_motion;
            r_poll.force_redraw  <= i_force_redraw;
            r_poll.redraw_ack    <= i_redraw_ack;
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_screen        = r_res.screen;
    assign o_in_standby    = r_res.in_standby;
    assign o_redraw_needed = r_res.redraw_needed;
    assign o_motion_wake   = r_res.motion_wake;
    assign o_gesture       = r_res.gesture;

endmodule

[hw/rtl/dwsc_checker.sv]
// Port-level checks for the display controller, bound to the top level.
// Depends on dwsc_pkg for the gesture codes.
module dwsc_checker
    import dwsc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_in_standby,
    input logic       o_redraw_needed,
    input logic       o_motion_wake,
    input logic [1:0] o_gesture
);

    // a stalled result stays presented
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // nothing is presented straight after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a gesture always wakes and requests a redraw
    a_gest_wakes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_gesture != GEST_NONE) |-> !o_in_standby && o_redraw_needed)
        else $error("gesture left display in standby or without redraw");

    // an accepted motion wake leaves the display awake
    a_motion_awake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_motion_wake |-> !o_in_standby)
        else $error("motion wake reported while in standby");

endmodule

bind display_wake_and_swipe_controller dwsc_checker u_dwsc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_in_standby    (o_in_standby),
    .o_redraw_needed (o_redraw_needed),
    .o_motion_wake   (o_motion_wake),
    .o_gesture       (o_gesture)
);
